>>> rtl/core/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types and constants for the counting semaphore with timed waits.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int CNT_W    = 16;
  localparam int INIT_W   = 15;
  localparam int TID_W    = 8;
  localparam int TMR_W    = 16;
  localparam int FUNC_W   = 2;
  localparam int OUTC_W   = 3;

  localparam logic signed [CNT_W-1:0] COUNT_TOP = 16'sd32767;

  // operation codes on the input tuser
  localparam logic [FUNC_W-1:0] FUNC_WAIT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  // result outcome codes on the output tuser
  localparam logic [OUTC_W-1:0] OUTC_GRANTED  = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_BLOCKED  = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_WOKEN    = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_TIMEDOUT = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_REJECTED = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SIG_EMIT,
    ST_TICK_RD,
    ST_TICK_EVAL,
    ST_TICK_FLUSH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;    // capture thread id and time limit
    logic wait_exec;   // grant, block or reject the latched wait
    logic sig_start;   // count up, read queue head
    logic sig_emit;    // pop head, send woken result
    logic tick_start;  // open a timer scan
    logic tick_read;   // read next entry of the scan
    logic tick_eval;   // retire or compact the entry just read
    logic tick_flush;  // close scan, send held result as last
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic total_zero;
    logic scan_done;
    logic expired;
    logic pend_valid;
  } status_t;

endpackage

>>> rtl/core/csem_ctrl.sv
// ----------------------------------------------------------------------------
// csem_ctrl
// Sequencer for wait, signal and tick operations.
// ----------------------------------------------------------------------------
module csem_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [csem_pkg::FUNC_W-1:0]  in_func,
  output logic                         in_ready,
  input  csem_pkg::status_t            status,
  output csem_pkg::cmd_t               cmd
);

  csem_pkg::state_t state, state_next;
  logic             accept;

  assign accept = in_valid && (state == csem_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csem_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      csem_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_func)
            csem_pkg::FUNC_WAIT:   state_next = csem_pkg::ST_WAIT;
            csem_pkg::FUNC_SIGNAL: begin
              if (!status.total_zero) state_next = csem_pkg::ST_SIG_EMIT;
            end
            csem_pkg::FUNC_TICK:   state_next = csem_pkg::ST_TICK_RD;
            default:               state_next = csem_pkg::ST_IDLE;
          endcase
        end
      end
      csem_pkg::ST_WAIT: begin
        if (status.out_free) state_next = csem_pkg::ST_IDLE;
      end
      csem_pkg::ST_SIG_EMIT: begin
        if (status.out_free) state_next = csem_pkg::ST_IDLE;
      end
      csem_pkg::ST_TICK_RD: begin
        state_next = status.scan_done ? csem_pkg::ST_TICK_FLUSH : csem_pkg::ST_TICK_EVAL;
      end
      csem_pkg::ST_TICK_EVAL: begin
        // a second expiry must first push out the held result
        if (!(status.expired && status.pend_valid && !status.out_free)) begin
          state_next = csem_pkg::ST_TICK_RD;
        end
      end
      csem_pkg::ST_TICK_FLUSH: begin
        if (!status.pend_valid || status.out_free) state_next = csem_pkg::ST_IDLE;
      end
      default: state_next = csem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      csem_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch_in   = accept;
        cmd.sig_start  = accept && (in_func == csem_pkg::FUNC_SIGNAL);
        cmd.tick_start = accept && (in_func == csem_pkg::FUNC_TICK);
      end
      csem_pkg::ST_WAIT:     cmd.wait_exec = status.out_free;
      csem_pkg::ST_SIG_EMIT: cmd.sig_emit  = status.out_free;
      csem_pkg::ST_TICK_RD:  cmd.tick_read = !status.scan_done;
      csem_pkg::ST_TICK_EVAL: begin
        cmd.tick_eval = !(status.expired && status.pend_valid && !status.out_free);
      end
      csem_pkg::ST_TICK_FLUSH: begin
        cmd.tick_flush = !status.pend_valid || status.out_free;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/csem_dp.sv
// ----------------------------------------------------------------------------
// csem_dp
// Count, circular waiter queue, timer scan and output register.
// ----------------------------------------------------------------------------
module csem_dp #(
  parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [csem_pkg::TID_W-1:0]          in_tid,
  input  logic [csem_pkg::TMR_W-1:0]          in_max,
  input  logic                                cfg_valid,
  input  logic [csem_pkg::INIT_W-1:0]         cfg_data,
  input  csem_pkg::cmd_t                      cmd,
  output csem_pkg::status_t                   status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [csem_pkg::TID_W-1:0]          out_tid,
  output logic [csem_pkg::OUTC_W-1:0]         out_outcome,
  output logic signed [csem_pkg::CNT_W-1:0]   out_count,
  output logic                                out_last
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int TW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = TW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam logic [TW-1:0] DEPTH_T = TW'(QUEUE_DEPTH);

  // head + offset, wrapped once; both terms are below the depth
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [TW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(ofs);
    if (sum >= DEPTH_S) sum = sum - DEPTH_S;
    return sum[IW-1:0];
  endfunction

  logic [csem_pkg::TID_W-1:0] id_mem  [QUEUE_DEPTH];
  logic [csem_pkg::TMR_W-1:0] tmr_mem [QUEUE_DEPTH];

  logic signed [csem_pkg::CNT_W-1:0] count, count_inc, count_dec;
  logic [IW-1:0]                     head;
  logic [TW-1:0]                     total;
  logic [TW-1:0]                     rd_cnt, wr_cnt, scan_len;
  logic [csem_pkg::TID_W-1:0]        op_tid, rd_id;
  logic [csem_pkg::TMR_W-1:0]        op_max, rd_tmr;
  logic                              pend_valid;
  logic [csem_pkg::TID_W-1:0]        pend_tid;
  logic signed [csem_pkg::CNT_W-1:0] pend_cnt;
  logic                              scan_on;

  logic                              wr_en;
  logic [IW-1:0]                     wr_addr, rd_addr;
  logic [csem_pkg::TID_W-1:0]        wr_id;
  logic [csem_pkg::TMR_W-1:0]        wr_tmr;

  logic                              emit_en, emit_last;
  logic [csem_pkg::TID_W-1:0]        emit_tid;
  logic [csem_pkg::OUTC_W-1:0]       emit_outc;
  logic signed [csem_pkg::CNT_W-1:0] emit_cnt;
  logic                              expired, granted, queue_full;

  assign count_inc  = (count < csem_pkg::COUNT_TOP) ? count + 16'sd1 : count;
  assign count_dec  = count - 16'sd1;
  assign expired    = (rd_tmr == csem_pkg::TMR_W'(1));
  assign granted    = (count > 16'sd0);
  assign queue_full = (total >= DEPTH_T);

  assign status.out_free   = !out_valid || out_ready;
  assign status.total_zero = (total == '0);
  assign status.scan_done  = (rd_cnt == scan_len);
  assign status.expired    = expired;
  assign status.pend_valid = pend_valid;

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wrap_add(head, total);
    wr_id   = op_tid;
    wr_tmr  = op_max;
    if (cmd.wait_exec && !granted && !queue_full) begin
      wr_en = 1'b1;
    end else if (cmd.tick_eval && !expired) begin
      wr_en   = 1'b1;
      wr_addr = wrap_add(head, wr_cnt);
      wr_id   = rd_id;
      wr_tmr  = (rd_tmr == '0) ? rd_tmr : rd_tmr - csem_pkg::TMR_W'(1);
    end
    // during a scan the address stays on the current entry, so a stalled
    // step keeps reading the same data
    rd_addr = scan_on ? wrap_add(head, rd_cnt) : head;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]  <= wr_id;
      tmr_mem[wr_addr] <= wr_tmr;
    end
    rd_id  <= id_mem[rd_addr];
    rd_tmr <= tmr_mem[rd_addr];
  end

  // result selection
  always_comb begin
    emit_en   = 1'b0;
    emit_tid  = op_tid;
    emit_outc = csem_pkg::OUTC_GRANTED;
    emit_cnt  = count;
    emit_last = 1'b1;
    if (cmd.wait_exec) begin
      emit_en = 1'b1;
      if (granted) begin
        emit_cnt = count_dec;
      end else if (queue_full) begin
        emit_outc = csem_pkg::OUTC_REJECTED;
      end else begin
        emit_outc = csem_pkg::OUTC_BLOCKED;
        emit_cnt  = count_dec;
      end
    end else if (cmd.sig_emit) begin
      emit_en   = 1'b1;
      emit_tid  = rd_id;
      emit_outc = csem_pkg::OUTC_WOKEN;
    end else if ((cmd.tick_eval && expired) || cmd.tick_flush) begin
      emit_en   = pend_valid;
      emit_tid  = pend_tid;
      emit_outc = csem_pkg::OUTC_TIMEDOUT;
      emit_cnt  = pend_cnt;
      emit_last = cmd.tick_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_tid <= in_tid;
      op_max <= in_max;
    end
    if (emit_en) begin
      out_tid     <= emit_tid;
      out_outcome <= emit_outc;
      out_count   <= emit_cnt;
      out_last    <= emit_last;
    end
    if (cmd.tick_eval && expired) begin
      pend_tid <= rd_id;
      pend_cnt <= count_inc;
    end
    if (cmd.tick_start) begin
      rd_cnt   <= '0;
      wr_cnt   <= '0;
      scan_len <= total;
    end
    if (cmd.tick_eval) begin
      rd_cnt <= rd_cnt + TW'(1);
      if (!expired) wr_cnt <= wr_cnt + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      head       <= '0;
      total      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      scan_on    <= 1'b0;
    end else begin
      if (emit_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        count <= csem_pkg::CNT_W'(cfg_data);
        head  <= '0;
        total <= '0;
      end else if (cmd.wait_exec) begin
        if (granted) begin
          count <= count_dec;
        end else if (!queue_full) begin
          count <= count_dec;
          total <= total + TW'(1);
        end
      end else if (cmd.sig_start) begin
        count <= count_inc;
      end else if (cmd.sig_emit) begin
        head  <= wrap_add(head, TW'(1));
        total <= total - TW'(1);
      end else if (cmd.tick_eval && expired) begin
        count <= count_inc;
      end else if (cmd.tick_flush) begin
        total <= wr_cnt;
      end

      if (cmd.tick_start || cmd.tick_flush) begin
        pend_valid <= 1'b0;
      end else if (cmd.tick_eval && expired) begin
        pend_valid <= 1'b1;
      end

      if (cmd.tick_start) begin
        scan_on <= 1'b1;
      end else if (cmd.tick_flush) begin
        scan_on <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/counting_semaphore_timed_wait.sv
// ----------------------------------------------------------------------------
// counting_semaphore_timed_wait
// Counting semaphore with a FIFO of blocked threads and per-waiter timeouts.
// ----------------------------------------------------------------------------
// One operation is taken at a time. A wait passes through the wait state, a
// signal with waiters through the signal-emit state, and a tick through a
// read and an evaluate state per waiter and a flush state, reading entries
// through the single registered read port of the waiter memory, writing
// survivors back compacted. Results leave through an output register, so a
// result waits there while the next step proceeds; a stalled output holds
// the sequencer only when a further result is due. The waiter memory needs
// no clearing after reset. A write on the config channel reloads the count
// and empties the queue; it is meant for idle periods only.
module counting_semaphore_timed_wait #(
  parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // [7:0] thread_id, [23:8] max_wait
  input  logic [1:0]  s_tuser,    // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [7:0] thread_id_out, [23:8] count_after
  output logic [2:0]  m_tuser,    // [2:0] outcome
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data    // init_count
);

  csem_pkg::cmd_t                    cmd;
  csem_pkg::status_t                 status;
  logic [csem_pkg::TID_W-1:0]        out_tid;
  logic signed [csem_pkg::CNT_W-1:0] out_count;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {out_count, out_tid};

  csem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  csem_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_tid      (s_tdata[7:0]),
    .in_max      (s_tdata[23:8]),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_tid     (out_tid),
    .out_outcome (m_tuser),
    .out_count   (out_count),
    .out_last    (m_tlast)
  );

endmodule

>>> rtl/core/csem_checker.sv
// ----------------------------------------------------------------------------
// csem_checker
// Port-level checks for the counting semaphore, bound to the top level.
// ----------------------------------------------------------------------------
module csem_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [14:0] cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result transfer right after reset");

  // only timeouts come several to one input
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != csem_pkg::OUTC_TIMEDOUT) |-> m_tlast)
    else $error("non-timeout result without tlast");

  // a wait always has a result pending, so no new transfer next cycle
  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == csem_pkg::FUNC_WAIT) |=> !s_tready)
    else $error("input taken while a wait is in progress");

  a_outc_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= csem_pkg::OUTC_REJECTED)
    else $error("undefined outcome code");

endmodule

bind counting_semaphore_timed_wait csem_checker u_csem_checker (.*);
